FILE: design/rsgf_pkg.sv
// ----------------------------------------------------------------------------
// rsgf_pkg: shared types, constants and GF(32) helpers
// Field GF(2)[x]/(x^5+x^2+1), primitive element alpha = 2. Holds the
// generator coefficients, the alpha power table and the per-cell item type.
// ----------------------------------------------------------------------------
package rsgf_pkg;

  localparam int SymW    = 5;
  localparam int NumData = 13;
  localparam int NumPar  = 4;
  localparam int NumSyn  = 4;
  localparam int DataW   = SymW * NumData;   // 65 bits of data symbols
  localparam int FieldN  = 31;               // multiplicative group order
  // Parity symbol k sits at code position 27+k; after Horner over 13 data
  // symbols the start value needs exponent i*(ParOfs+k).
  localparam int ParOfs  = 14;

  typedef logic [SymW-1:0] sym_t;

  localparam sym_t FieldPoly = 5'h05;        // x^2+1, x^5 implied

  // Generator coefficients, index 0 feeds the lowest parity register
  localparam sym_t GEN_COEF [NumPar] = '{5'd17, 5'd9, 5'd6, 5'd30};

  // alpha^k for k = 0..30
  localparam sym_t ALPHA_POW [FieldN] = '{
    5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd5,  5'd10, 5'd20,
    5'd13, 5'd26, 5'd17, 5'd7,  5'd14, 5'd28, 5'd29, 5'd31,
    5'd27, 5'd19, 5'd3,  5'd6,  5'd12, 5'd24, 5'd21, 5'd15,
    5'd30, 5'd25, 5'd23, 5'd11, 5'd22, 5'd9,  5'd18
  };

  // One word in flight: remaining data symbols (top symbol next), the
  // division register and the running syndrome accumulators.
  typedef struct packed {
    logic                  mode;
    logic [DataW-1:0]      data;
    sym_t [NumPar-1:0]     lfsr;
    sym_t [NumSyn-1:0]     syn;
  } item_t;

  // Shift-and-add multiply in GF(32); with a constant operand this folds
  // down to a small XOR network.
  function automatic sym_t gf_mul(input sym_t a, input sym_t b);
    sym_t acc;
    sym_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      sh = sh[SymW-1] ? ({sh[SymW-2:0], 1'b0} ^ FieldPoly) : {sh[SymW-2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

FILE: design/rsgf_cell.sv
// ----------------------------------------------------------------------------
// rsgf_cell: one step of the encoder/checker chain
// Takes the next data symbol off the top of the word, advances the parity
// division register by one symbol and steps each syndrome by Horner's rule.
// ----------------------------------------------------------------------------
module rsgf_cell
  import rsgf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  sym_t  sym;
  sym_t  fb;
  logic  load;

  // Stage takes a transfer when empty or when its content moves on
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // One division step and one Horner step per syndrome
  always_comb begin
    sym    = in_item_i.data[DataW-1 -: SymW];
    fb     = sym ^ in_item_i.lfsr[NumPar-1];
    item_d = in_item_i;
    item_d.data = {in_item_i.data[DataW-SymW-1:0], {SymW{1'b0}}};
    item_d.lfsr[0] = gf_mul(GEN_COEF[0], fb);
    for (int r = 1; r < NumPar; r++) begin
      item_d.lfsr[r] = in_item_i.lfsr[r-1] ^ gf_mul(GEN_COEF[r], fb);
    end
    for (int i = 0; i < NumSyn; i++) begin
      item_d.syn[i] = gf_mul(in_item_i.syn[i], ALPHA_POW[i+1]) ^ sym;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: design/rs_gf32_17_13_encode_check.sv
// ----------------------------------------------------------------------------
// rs_gf32_17_13_encode_check: shortened RS(17,13) encoder and checker, GF(32)
// Computes the four parity symbols of 13 data symbols and, in check mode,
// the syndromes S1..S4 of the word with the received parity appended.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries mode_i, data_low_i,
//   data_top_i and parity_in_i; a transfer happens on a clock edge with
//   valid high and stall low. Output channel out_valid_o / out_stall_i
//   carries parity_out_o, syndromes_o and word_ok_o, one result per word.
//   The word runs through a row of 13 cells, one data symbol per cell,
//   symbol 12 first; each cell is a register stage.
//   Each of the 13 cells registers the word on its way to out_valid_o.
//   Throughput: one word per cycle while out_stall_i is low, set by the one-symbol-per-cell chain.
//   Reset empties every stage; the block then takes input right away.
//   A stalled receiver holds the last stage; earlier stages keep filling
//   any empty slot, and in_stall_o rises once the chain has no room left.
//   In encode mode syndromes_o is zero and word_ok_o is low.
// ----------------------------------------------------------------------------
module rs_gf32_17_13_encode_check
  import rsgf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [59:0] data_low_i,
  input  logic [4:0]  data_top_i,
  input  logic [19:0] parity_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] parity_out_o,
  output logic [19:0] syndromes_o,
  output logic        word_ok_o
);

  item_t              chain_item [NumData+1];
  logic [NumData:0]   chain_valid;
  logic [NumData:0]   chain_ready;
  sym_t [NumPar-1:0]  par_sym;
  item_t              last_item;

  assign par_sym = parity_in_i;

  // Entry: received parity folded into the syndrome start values
  always_comb begin
    chain_item[0]      = '0;
    chain_item[0].mode = mode_i;
    chain_item[0].data = {data_top_i, data_low_i};
    for (int i = 0; i < NumSyn; i++) begin
      for (int k = 0; k < NumPar; k++) begin
        chain_item[0].syn[i] = chain_item[0].syn[i]
          ^ gf_mul(par_sym[k], ALPHA_POW[((i + 1) * (ParOfs + k)) % FieldN]);
      end
    end
  end

  assign chain_valid[0]       = in_valid_i;
  assign in_stall_o           = !chain_ready[0];
  assign chain_ready[NumData] = !out_stall_i;

  // Row of cells, one per data symbol
  for (genvar j = 0; j < NumData; j++) begin : g_cell
    rsgf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (chain_valid[j]),
      .in_ready_o (chain_ready[j]),
      .in_item_i  (chain_item[j]),
      .out_valid_o(chain_valid[j+1]),
      .out_ready_i(chain_ready[j+1]),
      .out_item_o (chain_item[j+1])
    );
  end

  // Result from the last stage
  assign last_item    = chain_item[NumData];
  assign out_valid_o  = chain_valid[NumData];
  assign parity_out_o = last_item.lfsr;
  assign syndromes_o  = last_item.mode ? last_item.syn : '0;
  assign word_ok_o    = last_item.mode && (last_item.syn == '0);

  // Accepted word lands in the first cell
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> chain_valid[1])
    else $error("accepted word missing from first cell");

  // Empty first cell never pushes back
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chain_valid[1] |-> !in_stall_o)
    else $error("input stalled with empty first cell");

  // Full chain with a stalled receiver blocks input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&chain_valid[NumData:1]) && out_stall_i) |-> in_stall_o)
    else $error("input taken while chain full and output stalled");

  // A stalled result stays in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(parity_out_o)))
    else $error("stalled result lost or changed");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RS(17,13) GF(32) encoder/checker
// Drives words through the valid/stall input channel and predicts parity,
// syndromes and the word-ok flag of each one in the bench's own GF(32)
// arithmetic. Covers directed corner words, good codewords, codewords with
// symbol errors, a long output hold-off and a large random run, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [4:0] symbol_t;

  typedef struct packed {
    logic [19:0] parity;
    logic [19:0] syn;
    logic        ok;
  } rs_result_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_CHECK  = 1'b1;

  // Generator coefficients of the division register, lowest stage first
  localparam symbol_t GEN0 = 5'd17;
  localparam symbol_t GEN1 = 5'd9;
  localparam symbol_t GEN2 = 5'd6;
  localparam symbol_t GEN3 = 5'd30;

  localparam int IDLE_PCT   = 27;
  localparam int LATENCY    = 13;
  localparam int NUM_RANDOM = 1600;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        mode_i      = 1'b0;
  logic [59:0] data_low_i  = '0;
  logic [4:0]  data_top_i  = '0;
  logic [19:0] parity_in_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [19:0] parity_out_o;
  logic [19:0] syndromes_o;
  logic        word_ok_o;

  rs_result_t pending_results [$];
  int         error_count  = 0;
  int         hold_request = 0;
  int         hold_left    = 0;
  bit         quiet        = 1'b0;

  rs_gf32_17_13_encode_check DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_low_i   (data_low_i),
    .data_top_i   (data_top_i),
    .parity_in_i  (parity_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .parity_out_o (parity_out_o),
    .syndromes_o  (syndromes_o),
    .word_ok_o    (word_ok_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // GF(32) multiply, field x^5+x^2+1
  function automatic symbol_t gf_times(symbol_t a, symbol_t b);
    symbol_t prod;
    symbol_t x;
    prod = '0;
    x    = a;
    for (int k = 0; k < 5; k++) begin
      if (b[k]) begin
        prod = prod ^ x;
      end
      x = {x[3:0], 1'b0} ^ (x[4] ? 5'h05 : 5'h00);
    end
    return prod;
  endfunction

  function automatic symbol_t alpha_to(int e);
    symbol_t p;
    p = 5'd1;
    repeat (e) p = gf_times(p, 5'd2);
    return p;
  endfunction

  // Parity by LFSR division, syndromes over code positions 0..12, 27..30
  function automatic rs_result_t rs_predict(logic mode, logic [59:0] low,
                                            logic [4:0] top, logic [19:0] par);
    symbol_t    word [17];
    symbol_t    lfsr [4];
    symbol_t    fb;
    symbol_t    acc;
    rs_result_t r;
    int         pos;
    for (int k = 0; k < 12; k++) word[k] = low[5*k +: 5];
    word[12] = top;
    for (int k = 0; k < 4; k++) word[13+k] = par[5*k +: 5];
    for (int k = 0; k < 4; k++) lfsr[k] = '0;
    for (int k = 12; k >= 0; k--) begin
      fb      = word[k] ^ lfsr[3];
      lfsr[3] = lfsr[2] ^ gf_times(GEN3, fb);
      lfsr[2] = lfsr[1] ^ gf_times(GEN2, fb);
      lfsr[1] = lfsr[0] ^ gf_times(GEN1, fb);
      lfsr[0] = gf_times(GEN0, fb);
    end
    r.parity = {lfsr[3], lfsr[2], lfsr[1], lfsr[0]};
    r.syn    = '0;
    r.ok     = 1'b0;
    if (mode == MODE_CHECK) begin
      for (int i = 1; i <= 4; i++) begin
        acc = '0;
        for (int k = 0; k < 17; k++) begin
          pos = (k < 13) ? k : k + 14;
          acc = acc ^ gf_times(word[k], alpha_to((i * pos) % 31));
        end
        r.syn[5*(i-1) +: 5] = acc;
      end
      r.ok = (r.syn == '0);
    end
    return r;
  endfunction

  // Send one word; returns right after the edge of its transfer
  task automatic send_word(logic mode, logic [59:0] low, logic [4:0] top,
                           logic [19:0] par);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_low_i  <= low;
    data_top_i  <= top;
    parity_in_i <= par;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(rs_predict(mode, low, top, par));
  endtask

  // Check a codeword with correct parity and an optional 85-bit error pattern
  task automatic send_codeword(logic [59:0] low, logic [4:0] top, logic [84:0] err);
    rs_result_t  enc;
    logic [19:0] par;
    enc = rs_predict(MODE_ENCODE, low, top, '0);
    par = enc.parity;
    send_word(MODE_CHECK, low ^ err[59:0], top ^ err[64:60], par ^ err[84:65]);
  endtask

  // Stop sending and wait until every expected result has come, then idle before returning
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // Random data, partly built from extreme symbols
  task automatic pick_data(output logic [59:0] low, output logic [4:0] top);
    if ($urandom_range(3) != 0) begin
      low = 60'({$urandom, $urandom});
      top = 5'($urandom);
    end else begin
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(2))
          0:       low[5*k +: 5] = 5'd0;
          1:       low[5*k +: 5] = 5'd31;
          default: low[5*k +: 5] = 5'($urandom);
        endcase
      end
      top = $urandom_range(1) ? 5'd31 : 5'(($urandom));
    end
  endtask

  // A nonzero error on one of the 17 symbols
  function automatic logic [84:0] symbol_error();
    logic [84:0] e;
    e = '0;
    e[5*$urandom_range(16) +: 5] = 5'($urandom_range(31, 1));
    return e;
  endfunction

  // Receiver: checks each transfer and decides its stall for the next edge
  always @(posedge clk_i) begin
    rs_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no word outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (parity_out_o !== want.parity) begin
            $error("parity_out: expected %h, actual %h", want.parity, parity_out_o);
            error_count++;
          end
          if (syndromes_o !== want.syn) begin
            $error("syndromes: expected %h, actual %h", want.syn, syndromes_o);
            error_count++;
          end
          if (word_ok_o !== want.ok) begin
            $error("word_ok: expected %b, actual %b", want.ok, word_ok_o);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Corner words: extremes, good codewords and single or double errors
  task automatic test_directed();
    send_word(MODE_ENCODE, '0, '0, '0);
    send_word(MODE_CHECK, '0, '0, '0);
    send_word(MODE_ENCODE, '1, '1, '1);
    send_word(MODE_CHECK, '1, '1, '1);
    send_word(MODE_CHECK, '0, '0, '1);
    send_word(MODE_ENCODE, '0, 5'd1, '0);
    send_word(MODE_ENCODE, 60'd1, '0, '0);
    send_word(MODE_ENCODE, {5'd31, 55'd0}, '0, '0);
    send_codeword('1, '1, '0);
    send_codeword('0, 5'd31, '0);
    send_codeword(60'h123456789abcdef, 5'd17, '0);
    send_codeword('1, '1, 85'd1);
    send_codeword('0, '0, {5'd31, 80'd0});
    send_codeword(60'hfedcba987654321, 5'd3, {20'd0, 5'd31, 60'd0});
    send_codeword(60'hfedcba987654321, 5'd3, {15'd0, 5'd7, 65'd0});
    send_codeword(60'h0f0f0f0f0f0f0f0, 5'd8, {5'd0, 5'd9, 15'd0, 5'd22, 55'd0});
    send_codeword('0, '0, 85'd31 << 40);
    send_word(MODE_CHECK, 60'h555555555555555, 5'd21, 20'haaaaa);
    send_word(MODE_ENCODE, 60'haaaaaaaaaaaaaaa, 5'd10, 20'h55555);
    send_word(MODE_CHECK, '1, '0, '0);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    logic [59:0] low;
    logic [4:0]  top;
    quiet        = 1'b1;
    hold_request = 80;
    repeat (40) begin
      pick_data(low, top);
      send_codeword(low, top, $urandom_range(1) ? symbol_error() : '0);
    end
    quiet = 1'b0;
  endtask

  // Sender pauses with words in flight until all results have come
  task automatic test_pause();
    logic [59:0] low;
    logic [4:0]  top;
    repeat (3) begin
      repeat ($urandom_range(12, 3)) begin
        pick_data(low, top);
        send_word(MODE_CHECK, low, top, 20'($urandom));
      end
      drain();
    end
  endtask

  // Mostly good and damaged codewords, the rest encode words and noise
  task automatic test_random(int count);
    logic [59:0] low;
    logic [4:0]  top;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3) && (n < count / 3 + 250);
      pick_data(low, top);
      case ($urandom_range(9))
        0, 1, 2, 3: send_codeword(low, top, '0);
        4:          send_codeword(low, top, symbol_error());
        5:          send_codeword(low, top, symbol_error() ^ symbol_error());
        6, 7:       send_word(MODE_ENCODE, low, top, 20'($urandom));
        default:    send_word(MODE_CHECK, low, top, 20'($urandom));
      endcase
    end
    quiet = 1'b0;
  endtask

  // Sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_backpressure();
    drain();
    test_pause();
    test_random(NUM_RANDOM);
    drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
